[design/hfrp_pkg.sv]
// Shared types and constants for the host frame response parser.
// Holds item kinds, marker bytes, status codes and the result record.
// No dependencies.
`default_nettype none

package hfrp_pkg;

    // input item kinds
    localparam logic [1:0] KIND_ARM     = 2'd0;
    localparam logic [1:0] KIND_BYTE    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    // frame marker bytes
    localparam logic [7:0] DIR_BYTE  = 8'hD5;
    localparam logic [7:0] MARK_FF   = 8'hFF;
    localparam logic [7:0] MARK_ZERO = 8'h00;

    // end status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NOT_PENDING = 4'd1;
    localparam logic [3:0] ST_BAD_HEADER  = 4'd2;
    localparam logic [3:0] ST_LEN_CSUM    = 4'd3;
    localparam logic [3:0] ST_NOT_REPLY   = 4'd4;
    localparam logic [3:0] ST_WRONG_CODE  = 4'd5;
    localparam logic [3:0] ST_LEN_SHORT   = 4'd6;
    localparam logic [3:0] ST_TOO_BIG     = 4'd7;
    localparam logic [3:0] ST_SHORT_DATA  = 4'd8;
    localparam logic [3:0] ST_SHORT_TRAIL = 4'd9;
    localparam logic [3:0] ST_DATA_CSUM   = 4'd10;
    localparam logic [3:0] ST_BAD_POST    = 4'd11;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd255;

    typedef struct packed {
        logic        is_end;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [3:0]  status;
        logic [15:0] payload_length;
    } t_result;

endpackage

`default_nettype wire

[design/hfrp_check.sv]
// Frame checking state machine: holds the parse state and produces at most
// one result per processed transaction. Depends on hfrp_pkg.
`default_nettype none

module hfrp_check (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire logic [1:0]      i_kind,
    input  wire logic [7:0]      i_sent_command,
    input  wire logic [7:0]      i_rx_byte,
    input  wire logic [15:0]     i_max_payload,
    output logic                 o_res_valid,
    output hfrp_pkg::t_result    o_res
);
    import hfrp_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_PRE, PH_START1, PH_START2, PH_LEN, PH_LCS, PH_EXT_HI,
        PH_EXT_LO, PH_EXT_CS, PH_DIR, PH_CODE, PH_DATA, PH_DCS, PH_POST
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_expected, n_expected;
    logic [7:0]  r_length_high, n_length_high;
    logic [15:0] r_frame_length, n_frame_length;
    logic [15:0] r_bytes_seen, n_bytes_seen;
    logic [7:0]  r_running_sum, n_running_sum;

    logic        finish;
    logic [3:0]  end_status;
    logic [15:0] end_length;
    logic [15:0] plen;
    logic [15:0] seen_inc;
    logic [7:0]  sum_byte;

    assign plen     = r_frame_length - 16'd2;
    assign seen_inc = r_bytes_seen + 16'd1;
    assign sum_byte = r_running_sum + i_rx_byte;

    always_comb begin
        n_phase        = r_phase;
        n_expected     = r_expected;
        n_length_high  = r_length_high;
        n_frame_length = r_frame_length;
        n_bytes_seen   = r_bytes_seen;
        n_running_sum  = r_running_sum;
        finish         = 1'b0;
        end_status     = ST_OK;
        end_length     = 16'd0;
        o_res_valid    = 1'b0;
        o_res          = '0;

        if (i_fire) begin
            unique case (i_kind)
                KIND_ARM: begin
                    // restart for the new command, dropping any frame in flight
                    n_expected     = i_sent_command + 8'd1;
                    n_length_high  = 8'd0;
                    n_frame_length = 16'd0;
                    n_bytes_seen   = 16'd0;
                    n_running_sum  = 8'd0;
                    n_phase        = PH_PRE;
                end
                KIND_BYTE: begin
                    unique case (r_phase)
                        PH_IDLE: ;
                        PH_PRE, PH_START1: begin
                            if (i_rx_byte != MARK_ZERO) begin
                                finish     = 1'b1;
                                end_status = ST_BAD_HEADER;
                            end else begin
                                n_phase = (r_phase == PH_PRE) ? PH_START1 : PH_START2;
                            end
                        end
                        PH_START2: begin
                            if (i_rx_byte != MARK_FF) begin
                                finish     = 1'b1;
                                end_status = ST_BAD_HEADER;
                            end else begin
                                n_phase = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            n_length_high = i_rx_byte;
                            n_phase       = PH_LCS;
                        end
                        PH_LCS: begin
                            priority if (r_length_high == MARK_FF && i_rx_byte == MARK_FF) begin
                                n_phase = PH_EXT_HI;
                            end else if (r_length_high + i_rx_byte != 8'd0) begin
                                finish     = 1'b1;
                                end_status = ST_LEN_CSUM;
                            end else begin
                                n_frame_length = {8'd0, r_length_high};
                                n_phase        = PH_DIR;
                            end
                        end
                        PH_EXT_HI: begin
                            n_length_high = i_rx_byte;
                            n_phase       = PH_EXT_LO;
                        end
                        PH_EXT_LO: begin
                            n_frame_length = {r_length_high, i_rx_byte};
                            n_running_sum  = r_length_high + i_rx_byte;
                            n_phase        = PH_EXT_CS;
                        end
                        PH_EXT_CS: begin
                            if (sum_byte != 8'd0) begin
                                finish     = 1'b1;
                                end_status = ST_LEN_CSUM;
                            end else begin
                                n_phase = PH_DIR;
                            end
                        end
                        PH_DIR: begin
                            if (i_rx_byte != DIR_BYTE) begin
                                finish     = 1'b1;
                                end_status = ST_NOT_REPLY;
                            end else begin
                                n_running_sum = DIR_BYTE;
                                n_phase       = PH_CODE;
                            end
                        end
                        PH_CODE: begin
                            priority if (i_rx_byte != r_expected) begin
                                finish     = 1'b1;
                                end_status = ST_WRONG_CODE;
                            end else if (r_frame_length < 16'd2) begin
                                finish     = 1'b1;
                                end_status = ST_LEN_SHORT;
                            end else if (plen > i_max_payload) begin
                                finish     = 1'b1;
                                end_status = ST_TOO_BIG;
                            end else begin
                                n_running_sum = sum_byte;
                                n_bytes_seen  = 16'd0;
                                // empty payload goes straight to the trailer
                                n_phase = (plen == 16'd0) ? PH_DCS : PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            o_res_valid         = 1'b1;
                            o_res.payload_byte  = i_rx_byte;
                            o_res.payload_index = r_bytes_seen;
                            n_running_sum       = sum_byte;
                            n_bytes_seen        = seen_inc;
                            if (seen_inc >= plen) begin
                                n_phase = PH_DCS;
                            end
                        end
                        PH_DCS: begin
                            n_running_sum = sum_byte;
                            n_phase       = PH_POST;
                        end
                        PH_POST: begin
                            finish = 1'b1;
                            priority if (r_running_sum != 8'd0) begin
                                end_status = ST_DATA_CSUM;
                            end else if (i_rx_byte != MARK_ZERO) begin
                                end_status = ST_BAD_POST;
                            end else begin
                                end_status = ST_OK;
                                end_length = plen;
                            end
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
                KIND_TIMEOUT: begin
                    finish = 1'b1;
                    unique case (r_phase)
                        PH_IDLE:         end_status = ST_NOT_PENDING;
                        PH_DATA:         end_status = ST_SHORT_DATA;
                        PH_DCS, PH_POST: end_status = ST_SHORT_TRAIL;
                        default:         end_status = ST_BAD_HEADER;
                    endcase
                end
                default: ;
            endcase
        end

        if (finish) begin
            o_res_valid          = 1'b1;
            o_res.is_end         = 1'b1;
            o_res.status         = end_status;
            o_res.payload_length = end_length;
            n_phase              = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_expected     <= 8'd0;
            r_length_high  <= 8'd0;
            r_frame_length <= 16'd0;
            r_bytes_seen   <= 16'd0;
            r_running_sum  <= 8'd0;
        end else begin
            r_phase        <= n_phase;
            r_expected     <= n_expected;
            r_length_high  <= n_length_high;
            r_frame_length <= n_frame_length;
            r_bytes_seen   <= n_bytes_seen;
            r_running_sum  <= n_running_sum;
        end
    end

endmodule

`default_nettype wire

[design/host_frame_response_parser_unit.sv]
// A transaction accepted into the input register passes through the check
// logic into the result register; while a result waits there and is not taken,
// the transaction is held in the input register.
// Throughput: one transaction per cycle, sustained while results are taken.
// Reset (synchronous, active low) returns the parser to idle with nothing
// pending, empties both registers and sets max_payload to 255.
`default_nettype none

module host_frame_response_parser_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_sent_command,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_is_end,
    output logic [7:0]       o_payload_byte,
    output logic [15:0]      o_payload_index,
    output logic [3:0]       o_status,
    output logic [15:0]      o_payload_length,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    import hfrp_pkg::*;

    logic        r_in_valid;
    logic [1:0]  r_in_kind;
    logic [7:0]  r_in_command;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_max_payload;

    logic        fire;
    logic        res_valid;
    t_result     res;

    // advance only when the result register is free or being emptied
    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_max_payload <= i_cfg_data;
            end
        end
        if (i_in_valid && o_in_ready) begin
            r_in_kind    <= i_kind;
            r_in_command <= i_sent_command;
            r_in_byte    <= i_rx_byte;
        end
    end

    hfrp_check u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_kind         (r_in_kind),
        .i_sent_command (r_in_command),
        .i_rx_byte      (r_in_byte),
        .i_max_payload  (r_max_payload),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_is_end         = r_out.is_end;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_payload_index  = r_out.payload_index;
    assign o_status         = r_out.status;
    assign o_payload_length = r_out.payload_length;

    // a new result never lands on one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // payload transactions carry no status and no length
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.is_end) |->
        (r_out.status == ST_OK && r_out.payload_length == 16'd0))
        else $error("payload result carries end fields");

    // only an ok end reports a length
    a_fail_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_end && r_out.status != ST_OK) |->
        (r_out.payload_length == 16'd0))
        else $error("failed frame reports a length");

endmodule

`default_nettype wire
